>>> design/irq_round_robin_distributor_defines.svh
// ----------------------------------------------------------------------------
// irq_round_robin_distributor_defines
// Assertion macros shared by the interrupt distributor RTL.
// ----------------------------------------------------------------------------
`ifndef IRQ_ROUND_ROBIN_DISTRIBUTOR_DEFINES_SVH
`define IRQ_ROUND_ROBIN_DISTRIBUTOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define IRQRR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define IRQRR_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> design/irqrr_pkg.sv
// ----------------------------------------------------------------------------
// irqrr_pkg
// Types, codes and helper functions of the interrupt distributor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package irqrr_pkg;

  localparam int MaskW  = 16;  // width of a CPU or line bit vector
  localparam int IdxW   = 4;   // width of a line or CPU number
  localparam int KindW  = 2;
  localparam int CfgIdxW = 2;

  // Result kinds
  localparam logic [KindW-1:0] KIND_LOCAL   = 2'd0;
  localparam logic [KindW-1:0] KIND_IPI     = 2'd1;
  localparam logic [KindW-1:0] KIND_AFF_OK  = 2'd2;
  localparam logic [KindW-1:0] KIND_AFF_REJ = 2'd3;

  // Commands
  localparam logic CMD_DISPATCH = 1'b0;
  localparam logic CMD_AFFINITY = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_LOCAL_MASK    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SERVICED_MASK = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_CPUS   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PACKAGE0_CPUS = 2'd3;

  // Reset values of the configuration registers
  localparam logic [MaskW-1:0] LOCAL_MASK_RST    = 16'd4487;
  localparam logic [MaskW-1:0] SERVICED_MASK_RST = 16'd53755;
  localparam logic [MaskW-1:0] ACTIVE_CPUS_RST   = 16'd65535;
  localparam logic [MaskW-1:0] PACKAGE0_CPUS_RST = 16'd15;

  // Outcome of the CPU selection for one line
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  cpu;
    logic             wr_last;  // store cpu as the line's last CPU
  } pick_t;

  // Number of the lowest set bit, zero when none is set.
  function automatic logic [IdxW-1:0] lowest_bit(input logic [MaskW-1:0] m);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = IdxW'(i);
      end
    end
    return r;
  endfunction

  // Bits strictly above position n.
  function automatic logic [MaskW-1:0] above_mask(input logic [IdxW-1:0] n);
    logic [MaskW-1:0] r;
    for (int i = 0; i < MaskW; i++) begin
      r[i] = (IdxW'(i) > n);
    end
    return r;
  endfunction

endpackage

>>> design/irqrr_ram.sv
// ----------------------------------------------------------------------------
// irqrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irqrr_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/irqrr_pick.sv
// ----------------------------------------------------------------------------
// irqrr_pick
// Round-robin CPU selection for one interrupt line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irqrr_pick (
  input  logic [irqrr_pkg::MaskW-1:0] aff_raw_i,    // stored affinity
  input  logic                        aff_valid_i,  // entry written since reset
  input  logic [irqrr_pkg::IdxW-1:0]  last_raw_i,   // stored last CPU
  input  logic                        last_valid_i, // last CPU exists
  input  logic                        is_local_i,
  input  logic [irqrr_pkg::MaskW-1:0] avail_i,      // active CPUs that exist
  output irqrr_pkg::pick_t            pick_o
);

  logic [irqrr_pkg::MaskW-1:0] aff;
  logic [irqrr_pkg::MaskW-1:0] after;
  logic [irqrr_pkg::IdxW-1:0]  cpu;

  always_comb begin
    aff   = (aff_valid_i ? aff_raw_i : '1) & avail_i;
    after = last_valid_i ? (aff & irqrr_pkg::above_mask(last_raw_i)) : aff;
    cpu   = irqrr_pkg::lowest_bit((after != '0) ? after : aff);

    if (is_local_i || (aff == '0)) begin
      pick_o.kind    = irqrr_pkg::KIND_LOCAL;
      pick_o.cpu     = '0;
      pick_o.wr_last = 1'b0;
    end else begin
      pick_o.kind    = (cpu == '0) ? irqrr_pkg::KIND_LOCAL : irqrr_pkg::KIND_IPI;
      pick_o.cpu     = cpu;
      pick_o.wr_last = 1'b1;
    end
  end

endmodule

>>> design/irq_round_robin_distributor.sv
// An affinity request answers in the cycle after accept; busy_o stays low.
// A dispatch request scans every line once, one line a cycle through the table RAM
// read ports, with busy_o high; pending lines report via the RAM and result registers.
// Throughput: one affinity request a cycle while busy_o is low, one dispatch per scan
// (lines capped at 16). Results are one-cycle strobes; the receiver cannot stall them.
// Reset loads the register defaults and clears the per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// irq_round_robin_distributor
// Interrupt distributor: affinity table updates and round-robin dispatch of a
// pending vector to the affine active CPUs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "irq_round_robin_distributor_defines.svh"

module irq_round_robin_distributor #(
  parameter int NUM_CPUS = 16,
  parameter int NUM_IRQS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          command_i,
  input  logic [irqrr_pkg::MaskW-1:0]   pending_i,
  input  logic [irqrr_pkg::IdxW-1:0]    irq_index_i,
  input  logic [irqrr_pkg::MaskW-1:0]   cpu_set_i,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irqrr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [irqrr_pkg::MaskW-1:0]   cfg_data_i,
  // results
  output logic                          result_valid_o,
  output logic [irqrr_pkg::KindW-1:0]   kind_o,
  output logic [irqrr_pkg::IdxW-1:0]    irq_out_o,
  output logic [irqrr_pkg::IdxW-1:0]    target_cpu_o,
  output logic                          last_o
);

  // Only the first 16 lines and CPUs fit the fixed-width fields.
  localparam int NumLines = (NUM_IRQS < irqrr_pkg::MaskW) ? NUM_IRQS : irqrr_pkg::MaskW;
  localparam int NumCpus  = (NUM_CPUS < irqrr_pkg::MaskW) ? NUM_CPUS : irqrr_pkg::MaskW;
  localparam int AddrW    = $clog2(NumLines);
  localparam logic [irqrr_pkg::MaskW-1:0] CpuExist =
    irqrr_pkg::MaskW'((17'd1 << NumCpus) - 17'd1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers: always ready; write only while idle (the block does not enforce it).
  // --------------------------------------------------------------------------
  logic [irqrr_pkg::MaskW-1:0] local_q, serviced_q, active_q, pkg0_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q    <= irqrr_pkg::LOCAL_MASK_RST;
      serviced_q <= irqrr_pkg::SERVICED_MASK_RST;
      active_q   <= irqrr_pkg::ACTIVE_CPUS_RST;
      pkg0_q     <= irqrr_pkg::PACKAGE0_CPUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        irqrr_pkg::REG_LOCAL_MASK:    local_q    <= cfg_data_i;
        irqrr_pkg::REG_SERVICED_MASK: serviced_q <= cfg_data_i;
        irqrr_pkg::REG_ACTIVE_CPUS:   active_q   <= cfg_data_i;
        irqrr_pkg::REG_PACKAGE0_CPUS: pkg0_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                        accept;
  logic                        aff_cmd;
  logic                        dsp_cmd;
  logic [irqrr_pkg::MaskW-1:0] aff_new;
  logic                        aff_in_range;
  logic                        aff_store;
  logic [AddrW-1:0]            aff_addr;

  assign accept       = start_i && !busy_o;
  assign aff_cmd      = accept && (command_i == irqrr_pkg::CMD_AFFINITY);
  assign dsp_cmd      = accept && (command_i == irqrr_pkg::CMD_DISPATCH);
  // Restrict the request to package-zero CPUs that exist.
  assign aff_new      = cpu_set_i & pkg0_q & CpuExist;
  assign aff_in_range = (32'(irq_index_i) < NumLines);
  assign aff_store    = aff_cmd && aff_in_range && (aff_new != '0);
  assign aff_addr     = irq_index_i[AddrW-1:0];

  // --------------------------------------------------------------------------
  // Scan sequencer: issue one RAM read per line, in ascending order.
  // --------------------------------------------------------------------------
  logic             state_q, state_d;
  logic [AddrW-1:0] scan_q, scan_d;
  logic [NumLines-1:0] pend_q;
  logic             scan_end;

  assign scan_end = (scan_q == AddrW'(NumLines - 1));

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    case (state_q)
      ST_IDLE: begin
        if (dsp_cmd) begin
          state_d = ST_SCAN;
          scan_d  = '0;
        end
      end
      ST_SCAN: begin
        scan_d = scan_q + AddrW'(1);
        if (scan_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  // Latch the serviced pending lines of the vector; lines beyond the table drop.
  always_ff @(posedge clk_i) begin
    if (dsp_cmd) begin
      pend_q <= pending_i[NumLines-1:0] & serviced_q[NumLines-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Table RAMs. Valid bits stand for the reset contents: an unwritten
  // affinity reads as all ones, an unwritten last CPU as none.
  // --------------------------------------------------------------------------
  logic                        rd_en;
  logic [irqrr_pkg::MaskW-1:0] aff_rdata;
  logic [irqrr_pkg::IdxW-1:0]  last_rdata;
  logic [NumLines-1:0]         aff_vld_q;
  logic [NumLines-1:0]         last_vld_q;

  logic                        s1_act_q;   // read data of line s1_line_q arrives
  logic                        s1_vld_q;   // and that line is pending
  logic [AddrW-1:0]            s1_line_q;
  irqrr_pkg::pick_t            pick;
  logic                        last_we;

  assign rd_en   = (state_q == ST_SCAN);
  assign last_we = s1_vld_q && pick.wr_last;

  irqrr_ram #(
    .Width (irqrr_pkg::MaskW),
    .Depth (NumLines)
  ) u_aff_ram (
    .clk_i   (clk_i),
    .we_i    (aff_store),
    .waddr_i (aff_addr),
    .wdata_i (aff_new),
    .re_i    (rd_en),
    .raddr_i (scan_q),
    .rdata_o (aff_rdata)
  );

  // Each line is visited once per scan and written in the cycle after its read,
  // so the write never overlaps a read of the same entry.
  irqrr_ram #(
    .Width (irqrr_pkg::IdxW),
    .Depth (NumLines)
  ) u_last_ram (
    .clk_i   (clk_i),
    .we_i    (last_we),
    .waddr_i (s1_line_q),
    .wdata_i (pick.cpu),
    .re_i    (rd_en),
    .raddr_i (scan_q),
    .rdata_o (last_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aff_vld_q  <= '0;
      last_vld_q <= '0;
    end else begin
      if (aff_store) begin
        aff_vld_q[aff_addr] <= 1'b1;
      end
      if (last_we) begin
        last_vld_q[s1_line_q] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Select stage: runs on the registered RAM data.
  // --------------------------------------------------------------------------
  logic [NumLines-1:0] local_lines;
  logic [NumLines-1:0] higher;
  logic                final_line;

  assign local_lines = local_q[NumLines-1:0];

  irqrr_pick u_pick (
    .aff_raw_i    (aff_rdata),
    .aff_valid_i  (aff_vld_q[s1_line_q]),
    .last_raw_i   (last_rdata),
    .last_valid_i (last_vld_q[s1_line_q]),
    .is_local_i   (local_lines[s1_line_q]),
    .avail_i      (active_q & CpuExist),
    .pick_o       (pick)
  );

  // Final result when no pending line lies above this one.
  always_comb begin
    for (int i = 0; i < NumLines; i++) begin
      higher[i] = (AddrW'(i) > s1_line_q);
    end
  end
  assign final_line = ((pend_q & higher) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_act_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      s1_act_q <= rd_en;
      s1_vld_q <= rd_en && pend_q[scan_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_line_q <= scan_q;
    end
  end

  assign busy_o = (state_q == ST_SCAN) || s1_act_q;

  // --------------------------------------------------------------------------
  // Result register: affinity answers and dispatch results never coincide,
  // since an affinity request is only taken while no scan is in flight.
  // --------------------------------------------------------------------------
  logic                        res_vld_q;
  logic [irqrr_pkg::KindW-1:0] kind_q;
  logic [irqrr_pkg::IdxW-1:0]  irq_q;
  logic [irqrr_pkg::IdxW-1:0]  cpu_q;
  logic                        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= aff_cmd || s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (aff_cmd) begin
      kind_q <= aff_store ? irqrr_pkg::KIND_AFF_OK : irqrr_pkg::KIND_AFF_REJ;
      irq_q  <= irq_index_i;
      cpu_q  <= '0;
      last_q <= 1'b1;
    end else if (s1_vld_q) begin
      kind_q <= pick.kind;
      irq_q  <= irqrr_pkg::IdxW'(s1_line_q);
      cpu_q  <= pick.cpu;
      last_q <= final_line;
    end
  end

  assign result_valid_o = res_vld_q;
  assign kind_o         = kind_q;
  assign irq_out_o      = irq_q;
  assign target_cpu_o   = cpu_q;
  assign last_o         = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `IRQRR_ASSERT(a_aff_answer, clk_i, rst_ni,
    aff_cmd |=> (result_valid_o && last_o &&
                 (kind_o == irqrr_pkg::KIND_AFF_OK || kind_o == irqrr_pkg::KIND_AFF_REJ)),
    "affinity request did not answer in the next cycle")
  `IRQRR_ASSERT(a_no_stray_result, clk_i, rst_ni,
    result_valid_o |-> ($past(accept) || $past(s1_vld_q)),
    "result without a request or a scanned line")
  `IRQRR_NEVER(a_accept_in_scan, clk_i, rst_ni,
    accept && (state_q == ST_SCAN || s1_act_q),
    "request taken while a scan is in flight")
  `IRQRR_ASSERT(a_ipi_not_cpu0, clk_i, rst_ni,
    (s1_vld_q && pick.kind == irqrr_pkg::KIND_IPI) |=> (target_cpu_o != '0),
    "IPI sent to the local core")

endmodule
